// ===== hw/rtl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and character constants of the JSON string escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

  // character and sequence sizes
  localparam int CHAR_W    = 21;
  localparam int MAX_CHARS = 14;
  localparam int CNT_W     = 4;

  // ascii codes used in quotes and escapes
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 21'h2F;
  localparam logic [CHAR_W-1:0] CH_LOW_B  = 21'h62;
  localparam logic [CHAR_W-1:0] CH_LOW_F  = 21'h66;
  localparam logic [CHAR_W-1:0] CH_LOW_N  = 21'h6E;
  localparam logic [CHAR_W-1:0] CH_LOW_R  = 21'h72;
  localparam logic [CHAR_W-1:0] CH_LOW_T  = 21'h74;
  localparam logic [CHAR_W-1:0] CH_LOW_U  = 21'h75;
  localparam logic [CHAR_W-1:0] CH_DIGIT0 = 21'h30;
  localparam logic [CHAR_W-1:0] CH_HEXA   = 21'h57;  // 'a' minus ten

  // input beat
  typedef struct packed {
    logic [CHAR_W-1:0] code_point;
    logic              has_char;
    logic              string_start;
    logic              string_end;
  } jse_in_t;

  // output beat
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
  } jse_out_t;

  // full character sequence of one item
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]                 count;
  } jse_seq_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jse_decode.sv =====
// ----------------------------------------------------------------------------
// jse_decode
// Expands one input beat into its quoted and escaped character sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_decode import jse_pkg::*; (
  input  jse_in_t  item_i,
  input  logic     esc_wide_i,
  output jse_seq_t seq_o
);

  // lower-case hex digit of a nibble
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] base;
    base = (nib < 4'd10) ? CH_DIGIT0 : CH_HEXA;
    return base + CHAR_W'(nib);
  endfunction

  logic [CHAR_W-1:0]                cp;
  logic [CHAR_W-1:0]                second;
  logic [CHAR_W-1:0]                reduced;
  logic [15:0]                      hi_unit;
  logic [15:0]                      lo_unit;
  logic [15:0]                      unit0;
  logic                             is_ctrl;
  logic                             is_big;
  logic                             is_wide;
  logic [CNT_W-1:0]                 body_len;
  logic [MAX_CHARS-1:0][CHAR_W-1:0] body;

  // classify the code point
  always_comb begin
    cp = item_i.code_point;
    unique case (cp)
      21'h08:  second = CH_LOW_B;
      21'h09:  second = CH_LOW_T;
      21'h0A:  second = CH_LOW_N;
      21'h0C:  second = CH_LOW_F;
      21'h0D:  second = CH_LOW_R;
      21'h22:  second = CH_QUOTE;
      21'h2F:  second = CH_SLASH;
      21'h5C:  second = CH_BSLASH;
      default: second = '0;
    endcase
    is_ctrl = (cp <= 21'h1F);
    is_big  = esc_wide_i && (cp > 21'hFFFF);
    is_wide = esc_wide_i && (cp > 21'h7E);
    reduced = cp - 21'h10000;
    hi_unit = 16'hD800 + 16'(reduced[20:10]);
    lo_unit = 16'hDC00 | {6'd0, reduced[9:0]};
    unit0   = is_big ? hi_unit : cp[15:0];
  end

  // body length by escape kind
  always_comb begin
    priority if (!item_i.has_char) begin
      body_len = CNT_W'(0);
    end else if (second != '0) begin
      body_len = CNT_W'(2);
    end else if (is_ctrl) begin
      body_len = CNT_W'(6);
    end else if (is_big) begin
      body_len = CNT_W'(12);
    end else if (is_wide) begin
      body_len = CNT_W'(6);
    end else begin
      body_len = CNT_W'(1);
    end
  end

  // body characters, unused tail entries are don't care
  always_comb begin
    body     = '0;
    body[0]  = (body_len == CNT_W'(1)) ? cp : CH_BSLASH;
    body[1]  = (second != '0) ? second : CH_LOW_U;
    body[2]  = hex_char(unit0[15:12]);
    body[3]  = hex_char(unit0[11:8]);
    body[4]  = hex_char(unit0[7:4]);
    body[5]  = hex_char(unit0[3:0]);
    body[6]  = CH_BSLASH;
    body[7]  = CH_LOW_U;
    body[8]  = hex_char(lo_unit[15:12]);
    body[9]  = hex_char(lo_unit[11:8]);
    body[10] = hex_char(lo_unit[7:4]);
    body[11] = hex_char(lo_unit[3:0]);
  end

  // wrap the body in the requested quotes
  always_comb begin
    seq_o.count = CNT_W'(item_i.string_start) + body_len + CNT_W'(item_i.string_end);
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (item_i.string_start) begin
        if (i == 0) begin
          seq_o.chars[i] = CH_QUOTE;
        end else if (CNT_W'(i - 1) < body_len) begin
          seq_o.chars[i] = body[CNT_W'(i - 1)];
        end else begin
          seq_o.chars[i] = CH_QUOTE;
        end
      end else if (CNT_W'(i) < body_len) begin
        seq_o.chars[i] = body[CNT_W'(i)];
      end else begin
        seq_o.chars[i] = CH_QUOTE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jse_emitter.sv =====
// ----------------------------------------------------------------------------
// jse_emitter
// Holds one decoded sequence and sends it out a character per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_emitter import jse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  jse_seq_t seq_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output jse_out_t out_data_o
);

  jse_seq_t         seq_q;
  logic             seq_valid_q;
  logic [CNT_W-1:0] idx_q;
  logic             out_valid_q;
  jse_out_t         out_q;

  logic out_free;
  logic at_last;
  logic emit;
  logic load;

  // handshake control
  assign out_free   = !out_valid_q || out_ready_i;
  assign at_last    = (idx_q == seq_q.count - CNT_W'(1));
  assign emit       = seq_valid_q && out_free;
  assign in_ready_o = !seq_valid_q || (emit && at_last);
  assign load       = in_valid_i && in_ready_o;

  // sequence and output control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        seq_valid_q <= (seq_i.count != '0);
        idx_q       <= '0;
      end else if (emit) begin
        if (at_last) begin
          seq_valid_q <= 1'b0;
          idx_q       <= '0;
        end else begin
          idx_q <= idx_q + CNT_W'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      seq_q <= seq_i;
    end
    if (emit) begin
      out_q.out_char <= seq_q.chars[idx_q];
      out_q.run_last <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_q |-> (seq_q.count != '0) && (idx_q < seq_q.count))
    else $error("character index past sequence end");
  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_valid_q |-> (idx_q == '0))
    else $error("index not cleared while no sequence held");
  a_idx_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !at_last) |=> seq_valid_q && (idx_q == $past(idx_q) + CNT_W'(1)))
    else $error("index did not advance after a character");
  a_no_load_mid_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_valid_q && !(emit && at_last)) |-> !in_ready_o)
    else $error("new beat taken while sequence still pending");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/json_string_escaper_top.sv =====
// path: a character beat is held in the emitter's sequence register and then in its output register
// throughput: one input beat per cycle while each gives at most one character and the output is not stalled
// an item of n characters (up to 14) holds the input until its last character is emitted: one output
// register sends one character per cycle while out_ready_i does not hold it
// reset: asynchronous active low, clears esc_wide and all pending sequences
// ----------------------------------------------------------------------------
// json_string_escaper_top
// Streams code points into JSON-quoted, escaped output characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_string_escaper_top import jse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_data_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  jse_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output jse_out_t out_data_o
);

  logic     esc_wide_q;
  jse_seq_t seq;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_wide_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      esc_wide_q <= cfg_data_i;
    end
  end

  // escape expansion
  jse_decode u_decode (
    .item_i     (in_data_i),
    .esc_wide_i (esc_wide_q),
    .seq_o      (seq)
  );

  // character sequencing
  jse_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .seq_i       (seq),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
